// ----- src/mod_fibonacci_nth_term_assert.svh -----
// assertion macros for the fibonacci term generator
`ifndef MOD_FIBONACCI_NTH_TERM_ASSERT_SVH
`define MOD_FIBONACCI_NTH_TERM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FNT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define FNT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/fnt_pkg.sv -----
// shared types, constants and helpers of the fibonacci term generator
`timescale 1ns / 1ps

package fnt_pkg;

	localparam int INDEX_BITS     = 32;
	localparam int VALUE_BITS     = 30;
	localparam int MUL_BITS       = 32;
	localparam int PROD_BITS      = 2 * MUL_BITS;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [VALUE_BITS-1:0] PRIME_MOD = 30'd998244353;

	// barrett factor floor(2^60 / p) for p below 2^30
	localparam logic [MUL_BITS-1:0] BARRETT_MU =
		MUL_BITS'((64'd1 << 60) / 64'(PRIME_MOD));

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_TERM  = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SECOND_TERM = 1'd1;

	typedef enum logic [2:0] {
		MAC_IDLE,
		MAC_PROD,
		MAC_EST,
		MAC_QP,
		MAC_SUB,
		MAC_FIX,
		MAC_DONE
	} mac_state_t;

	typedef enum logic [2:0] {
		TOP_IDLE,
		TOP_BIT,
		TOP_START,
		TOP_MAC,
		TOP_EMIT
	} top_state_t;

	typedef enum logic [1:0] {
		OP_ACC,
		OP_SQR,
		OP_FIN
	} mat_op_t;

	// request to the modular multiply-add unit: (a*b + c*d) mod p
	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] op_a;
		logic [VALUE_BITS-1:0] op_b;
		logic [VALUE_BITS-1:0] op_c;
		logic [VALUE_BITS-1:0] op_d;
	} mac_req_t;

	typedef struct packed {
		logic                  done;
		logic [VALUE_BITS-1:0] value;
	} mac_rsp_t;

	// (x - y) mod p for reduced operands
	function automatic logic [VALUE_BITS-1:0] mod_sub(
		input logic [VALUE_BITS-1:0] x,
		input logic [VALUE_BITS-1:0] y
	);
		logic [VALUE_BITS:0] wide;
		begin
			wide = {1'b0, x} + {1'b0, PRIME_MOD} - {1'b0, y};
			if (x >= y) begin
				mod_sub = x - y;
			end else begin
				mod_sub = wide[VALUE_BITS-1:0];
			end
		end
	endfunction

	// one conditional subtract: any 30-bit value is below twice p
	function automatic logic [VALUE_BITS-1:0] mod_fold(input logic [VALUE_BITS-1:0] x);
		begin
			if (x >= PRIME_MOD) begin
				mod_fold = x - PRIME_MOD;
			end else begin
				mod_fold = x;
			end
		end
	endfunction

endpackage

// ----- src/fnt_index_if.sv -----
// input channel carrying the wanted term index
`timescale 1ns / 1ps

interface fnt_index_if;
	logic                            valid;
	logic                            ready;
	logic [fnt_pkg::INDEX_BITS-1:0]  term_index;

	modport source (output valid, output term_index, input ready);
	modport sink (input valid, input term_index, output ready);
endinterface

// ----- src/fnt_value_if.sv -----
// output channel carrying the computed term value
`timescale 1ns / 1ps

interface fnt_value_if;
	logic                            valid;
	logic                            ready;
	logic [fnt_pkg::VALUE_BITS-1:0]  term_value;

	modport source (output valid, output term_value, input ready);
	modport sink (input valid, input term_value, output ready);
endinterface

// ----- src/mod_fibonacci_nth_term.sv -----
// Fibonacci-type term n modulo 998244353 by square-and-multiply on the matrix [[1,1],[1,0]].
// Indices zero to two need no matrix work; otherwise every modular multiply-add runs on the
// single shared multiplier, two per matrix product, one product per set exponent bit plus
// one squaring per bit below the highest set bit.
// Throughput: one item at a time; the next index is taken once the result sits in the output.
// Reset: asynchronous, active low; seeds return to 1 and 2, no result pending.
`timescale 1ns / 1ps
`include "mod_fibonacci_nth_term_assert.svh"

module mod_fibonacci_nth_term (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fnt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [fnt_pkg::VALUE_BITS-1:0]      cfg_data,
	fnt_index_if.sink                           idx,
	fnt_value_if.source                         term
);

	fnt_pkg::top_state_t state_q;
	fnt_pkg::top_state_t state_d;
	fnt_pkg::mat_op_t    op_q;

	logic                              entry_q;
	logic [fnt_pkg::INDEX_BITS-1:0]    e_q;
	logic [fnt_pkg::VALUE_BITS-1:0]    seed_one_q;
	logic [fnt_pkg::VALUE_BITS-1:0]    seed_two_q;
	logic [fnt_pkg::VALUE_BITS-1:0]    acc0_q;
	logic [fnt_pkg::VALUE_BITS-1:0]    acc1_q;
	logic [fnt_pkg::VALUE_BITS-1:0]    base0_q;
	logic [fnt_pkg::VALUE_BITS-1:0]    base1_q;
	logic [fnt_pkg::VALUE_BITS-1:0]    t0_q;
	logic [fnt_pkg::VALUE_BITS-1:0]    pend_q;
	logic [fnt_pkg::VALUE_BITS-1:0]    out_q;
	logic                              out_valid_q;

	logic [fnt_pkg::VALUE_BITS-1:0]    f1;
	logic [fnt_pkg::VALUE_BITS-1:0]    f2;
	logic [fnt_pkg::VALUE_BITS-1:0]    base3;
	logic [fnt_pkg::VALUE_BITS-1:0]    short_val;
	logic                              short_idx;
	logic                              in_xfer;
	logic                              out_free;
	logic                              e_last;

	fnt_pkg::mac_req_t mac_req;
	fnt_pkg::mac_rsp_t mac_rsp;

	fnt_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	// reduced seeds and the lower-right entry of the base power
	assign f1    = fnt_pkg::mod_fold(seed_one_q);
	assign f2    = fnt_pkg::mod_fold(seed_two_q);
	assign base3 = fnt_pkg::mod_sub(base0_q, base1_q);

	// indices zero to two need no matrix work
	assign short_idx = (idx.term_index[fnt_pkg::INDEX_BITS-1:2] == '0) &&
		(idx.term_index[1:0] != 2'd3);
	always_comb begin
		case (idx.term_index[1:0])
			2'd0:    short_val = fnt_pkg::mod_sub(f2, f1);
			2'd1:    short_val = f1;
			default: short_val = f2;
		endcase
	end

	assign in_xfer  = idx.valid && idx.ready;
	assign out_free = !out_valid_q || term.ready;
	assign e_last   = ((e_q >> 1) == '0);

	assign term.valid      = out_valid_q;
	assign term.term_value = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fnt_pkg::TOP_IDLE: begin
				if (idx.valid) begin
					state_d = short_idx ? fnt_pkg::TOP_EMIT : fnt_pkg::TOP_BIT;
				end
			end
			fnt_pkg::TOP_BIT:   state_d = fnt_pkg::TOP_START;
			fnt_pkg::TOP_START: state_d = fnt_pkg::TOP_MAC;
			fnt_pkg::TOP_MAC: begin
				if (mac_rsp.done) begin
					case (op_q)
						fnt_pkg::OP_FIN: state_d = fnt_pkg::TOP_EMIT;
						fnt_pkg::OP_ACC: begin
							if (!entry_q) begin
								state_d = fnt_pkg::TOP_START;
							end else begin
								state_d = e_last ? fnt_pkg::TOP_BIT : fnt_pkg::TOP_START;
							end
						end
						default: begin
							state_d = entry_q ? fnt_pkg::TOP_BIT : fnt_pkg::TOP_START;
						end
					endcase
				end
			end
			fnt_pkg::TOP_EMIT: begin
				if (out_free) begin
					state_d = fnt_pkg::TOP_IDLE;
				end
			end
			default: state_d = fnt_pkg::TOP_IDLE;
		endcase
	end

	// handshake and multiply-add operand selection
	always_comb begin
		idx.ready     = (state_q == fnt_pkg::TOP_IDLE);
		mac_req.start = (state_q == fnt_pkg::TOP_START);
		case (op_q)
			fnt_pkg::OP_ACC: begin
				mac_req.op_a = acc0_q;
				mac_req.op_b = entry_q ? base1_q : base0_q;
				mac_req.op_c = acc1_q;
				mac_req.op_d = entry_q ? base3 : base1_q;
			end
			fnt_pkg::OP_SQR: begin
				mac_req.op_a = base0_q;
				mac_req.op_b = entry_q ? base1_q : base0_q;
				mac_req.op_c = base1_q;
				mac_req.op_d = entry_q ? base3 : base1_q;
			end
			default: begin
				mac_req.op_a = acc0_q;
				mac_req.op_b = f2;
				mac_req.op_c = acc1_q;
				mac_req.op_d = f1;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fnt_pkg::TOP_IDLE;
			op_q        <= fnt_pkg::OP_FIN;
			entry_q     <= 1'b0;
			out_valid_q <= 1'b0;
			seed_one_q  <= fnt_pkg::VALUE_BITS'(1);
			seed_two_q  <= fnt_pkg::VALUE_BITS'(2);
		end else begin
			state_q <= state_d;

			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					fnt_pkg::REG_FIRST_TERM:  seed_one_q <= cfg_data;
					fnt_pkg::REG_SECOND_TERM: seed_two_q <= cfg_data;
					default:                  seed_one_q <= seed_one_q;
				endcase
			end

			// choose the next matrix operation from the low exponent bit
			if (state_q == fnt_pkg::TOP_BIT) begin
				entry_q <= 1'b0;
				if (e_q == '0) begin
					op_q <= fnt_pkg::OP_FIN;
				end else if (e_q[0]) begin
					op_q <= fnt_pkg::OP_ACC;
				end else begin
					op_q <= fnt_pkg::OP_SQR;
				end
			end else if (state_q == fnt_pkg::TOP_MAC && mac_rsp.done) begin
				if (!entry_q) begin
					entry_q <= 1'b1;
				end else if (op_q == fnt_pkg::OP_ACC && !e_last) begin
					op_q    <= fnt_pkg::OP_SQR;
					entry_q <= 1'b0;
				end
			end

			// output register
			if (state_q == fnt_pkg::TOP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (term.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// matrix entries, exponent and result registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pend_q  <= short_val;
			e_q     <= idx.term_index - fnt_pkg::INDEX_BITS'(2);
			acc0_q  <= fnt_pkg::VALUE_BITS'(1);
			acc1_q  <= '0;
			base0_q <= fnt_pkg::VALUE_BITS'(1);
			base1_q <= fnt_pkg::VALUE_BITS'(1);
		end else if (state_q == fnt_pkg::TOP_MAC && mac_rsp.done) begin
			if (op_q == fnt_pkg::OP_FIN) begin
				pend_q <= mac_rsp.value;
			end else if (!entry_q) begin
				t0_q <= mac_rsp.value;
			end else if (op_q == fnt_pkg::OP_ACC) begin
				acc0_q <= t0_q;
				acc1_q <= mac_rsp.value;
				if (e_last) begin
					e_q <= '0;
				end
			end else begin
				base0_q <= t0_q;
				base1_q <= mac_rsp.value;
				e_q     <= e_q >> 1;
			end
		end
		if (state_q == fnt_pkg::TOP_EMIT && out_free) begin
			out_q <= pend_q;
		end
	end

	// checks
	`FNT_ASSERT_SAME(a_value_reduced, term.valid, term.term_value < fnt_pkg::PRIME_MOD, "result not reduced")
	`FNT_ASSERT_SAME(a_mac_done_waited, mac_rsp.done, state_q == fnt_pkg::TOP_MAC, "multiply-add finished while not awaited")
	`FNT_ASSERT_NEXT(a_emit_loads, state_q == fnt_pkg::TOP_EMIT, term.valid, "pending result not presented")

endmodule

// ----- src/fnt_mul.sv -----
// shared 32 x 32 unsigned multiplier with registered product
`timescale 1ns / 1ps

module fnt_mul (
	input  logic                           clk,
	input  logic [fnt_pkg::MUL_BITS-1:0]   a,
	input  logic [fnt_pkg::MUL_BITS-1:0]   b,
	output logic [fnt_pkg::PROD_BITS-1:0]  prod_q
);

	// product register
	always_ff @(posedge clk) begin
		prod_q <= fnt_pkg::PROD_BITS'(a) * fnt_pkg::PROD_BITS'(b);
	end

endmodule

// ----- src/fnt_mac.sv -----
// modular multiply-add unit: two products, barrett reduction on one multiplier
`timescale 1ns / 1ps

module fnt_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  fnt_pkg::mac_req_t req,
	output fnt_pkg::mac_rsp_t rsp
);

	fnt_pkg::mac_state_t state_q;
	fnt_pkg::mac_state_t state_d;

	logic                                 sel_q;
	logic [fnt_pkg::VALUE_BITS-1:0]       sum_q;
	logic [fnt_pkg::MUL_BITS-1:0]         x_lo_q;
	logic [fnt_pkg::MUL_BITS-1:0]         r_q;
	logic [fnt_pkg::MUL_BITS-1:0]         mul_a;
	logic [fnt_pkg::MUL_BITS-1:0]         mul_b;
	logic [fnt_pkg::PROD_BITS-1:0]        mul_p;
	logic                                 r_big;
	logic [fnt_pkg::VALUE_BITS:0]         sum_wide;
	logic [fnt_pkg::VALUE_BITS-1:0]       sum_next;

	fnt_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (mul_p)
	);

	// remainder still needs a correction step
	assign r_big = (r_q >= {2'b00, fnt_pkg::PRIME_MOD});

	// running sum of the two reduced products
	always_comb begin
		sum_wide = {1'b0, sum_q} + {1'b0, r_q[fnt_pkg::VALUE_BITS-1:0]};
		if (sum_wide >= {1'b0, fnt_pkg::PRIME_MOD}) begin
			sum_wide = sum_wide - {1'b0, fnt_pkg::PRIME_MOD};
		end
		sum_next = sum_wide[fnt_pkg::VALUE_BITS-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fnt_pkg::MAC_IDLE: begin
				if (req.start) begin
					state_d = fnt_pkg::MAC_PROD;
				end
			end
			fnt_pkg::MAC_PROD: state_d = fnt_pkg::MAC_EST;
			fnt_pkg::MAC_EST:  state_d = fnt_pkg::MAC_QP;
			fnt_pkg::MAC_QP:   state_d = fnt_pkg::MAC_SUB;
			fnt_pkg::MAC_SUB:  state_d = fnt_pkg::MAC_FIX;
			fnt_pkg::MAC_FIX: begin
				if (!r_big) begin
					state_d = sel_q ? fnt_pkg::MAC_DONE : fnt_pkg::MAC_PROD;
				end
			end
			fnt_pkg::MAC_DONE: state_d = fnt_pkg::MAC_IDLE;
			default:           state_d = fnt_pkg::MAC_IDLE;
		endcase
	end

	// multiplier operand selection and response
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		rsp.done  = 1'b0;
		rsp.value = sum_q;
		case (state_q)
			fnt_pkg::MAC_PROD: begin
				mul_a = {2'b00, (sel_q ? req.op_c : req.op_a)};
				mul_b = {2'b00, (sel_q ? req.op_d : req.op_b)};
			end
			fnt_pkg::MAC_EST: begin
				// quotient estimate: (x >> 29) * mu
				mul_a = {1'b0, mul_p[59:29]};
				mul_b = fnt_pkg::BARRETT_MU;
			end
			fnt_pkg::MAC_QP: begin
				// q = estimate >> 31, times p
				mul_a = {1'b0, mul_p[61:31]};
				mul_b = {2'b00, fnt_pkg::PRIME_MOD};
			end
			fnt_pkg::MAC_DONE: rsp.done = 1'b1;
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fnt_pkg::MAC_IDLE;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fnt_pkg::MAC_IDLE && req.start) begin
				sel_q <= 1'b0;
			end else if (state_q == fnt_pkg::MAC_FIX && !r_big) begin
				sel_q <= 1'b1;
			end
		end
	end

	// datapath registers; remainder below 3p fits 32 bits
	always_ff @(posedge clk) begin
		case (state_q)
			fnt_pkg::MAC_IDLE: begin
				if (req.start) begin
					sum_q <= '0;
				end
			end
			fnt_pkg::MAC_EST: x_lo_q <= mul_p[fnt_pkg::MUL_BITS-1:0];
			fnt_pkg::MAC_SUB: r_q <= x_lo_q - mul_p[fnt_pkg::MUL_BITS-1:0];
			fnt_pkg::MAC_FIX: begin
				if (r_big) begin
					r_q <= r_q - {2'b00, fnt_pkg::PRIME_MOD};
				end else begin
					sum_q <= sum_next;
				end
			end
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

endmodule
